[sv/shdq_pkg.sv]
// ----------------------------------------------------------------------------
// shdq_pkg: shared types and constants for the stereo dither quantizer
// Sequencer states, register map, reset values and the xorshift32 step.
// ----------------------------------------------------------------------------
package shdq_pkg;

  // default parameter values
  localparam int unsigned DITHER_DELAY_DEF = 4;
  localparam int unsigned SAMPLE_BITS_DEF  = 32;

  // configuration port geometry
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 64;

  // register select, taken from the 8-byte register slot bit of paddr
  localparam logic CFG_SEL_SCALE = 1'b0;
  localparam logic CFG_SEL_RECIP = 1'b1;

  // register widths and reset values
  localparam int unsigned SCALE_W = 40;
  localparam int unsigned RECIP_W = 30;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 40'd2147483648;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 30'd131072;

  // generator seeds
  localparam logic [31:0] SEED_LEFT  = 32'h2545_F491;
  localparam logic [31:0] SEED_RIGHT = 32'h9E37_79B9;

  // channel codes
  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_MUL_RC,
    ST_FIN,
    ST_OUT
  } state_e;

  // one xorshift32 step, shifts 13, 17, 5
  function automatic logic [31:0] xs_next(input logic [31:0] x);
    logic [31:0] t;
    t = x ^ (x << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

endpackage

[sv/stereo_highpass_dither_quantizer.sv]
// ----------------------------------------------------------------------------
// stereo_highpass_dither_quantizer: xorshift32 highpassed dither quantizer
// Scales a stereo sample pair, adds highpassed dither, floors, rescales by
// a software reciprocal and saturates, one channel after the other.
// ----------------------------------------------------------------------------
// Usage
//   Input items arrive on s_axis: tdata holds the left sample in bits 31:0
//   and the right sample in bits 63:32, tlast marks the end of a block.
//   Results leave on m_axis in the same layout, tlast copied through.
//   The APB port holds the scale (address 0x0) and the output reciprocal
//   (address 0x8); write them only while no item is in flight.
// Sequencing
//   One 33x31 multiplier is shared under a small sequencer: five steps
//   per channel (low product, high product, sum, reciprocal product,
//   round and saturate), left then right, then an output step. An item
//   shows up on m_axis once both channels are done; no new item is taken
//   until the sequencer is back in idle, after the output register is free.
// Reset and stall
//   Reset loads the generator seeds, clears the dither history and loads
//   the register defaults. The result sits in an output register; the
//   next item is taken and worked while it waits, and the sequencer only
//   holds in its last step until that register is free.
// ----------------------------------------------------------------------------
module stereo_highpass_dither_quantizer
  import shdq_pkg::*;
#(
  parameter int unsigned DITHER_DELAY = DITHER_DELAY_DEF,
  parameter int unsigned SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,  // sample_left, sample_right
  input  logic                  s_axis_tlast,  // block_end
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [63:0]           m_axis_tdata,  // out_left, out_right
  output logic                  m_axis_tlast,  // block_end_out
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IN_SHIFT = 32 - SAMPLE_BITS;
  localparam int unsigned RND_K    = 33 - SAMPLE_BITS;
  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (RND_K - 1);
  localparam logic signed [63:0] SAT_MAX  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_MIN  = -SAT_MAX - 64'sd1;

  // registers
  state_e                    state_q, state_d;
  logic                      ch_q, ch_d;
  logic [SCALE_W-1:0]        scale_q;
  logic [RECIP_W-1:0]        recip_q;
  logic [31:0]               smp_q [2];
  logic                      last_q;
  logic [31:0]               prng_q [2];
  logic [31:0]               hist_q [2][DITHER_DELAY];
  logic signed [63:0]        prod_q;
  logic signed [49:0]        e_q;
  logic signed [25:0]        qnt_q;
  logic [31:0]               res_left_q;
  logic [31:0]               res_right_q;
  logic                      out_valid_q;
  logic [63:0]               out_data_q;
  logic                      out_last_q;

  // datapath signals
  logic signed [32:0]        mul_a;
  logic signed [30:0]        mul_b;
  logic signed [63:0]        mul_p;
  logic [31:0]               prng_cur;
  logic [31:0]               hist_old;
  logic signed [32:0]        dith_diff;
  logic signed [49:0]        e_sum;
  logic signed [56:0]        t_sum;
  logic signed [63:0]        v_rnd;
  logic signed [63:0]        r_val;
  logic signed [63:0]        r_sat;
  logic [31:0]               res_cur;
  logic                      in_fire;
  logic                      out_load;
  logic                      cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[3] == CFG_SEL_RECIP) ? {{(CFG_DATA_W-RECIP_W){1'b0}}, recip_q}
                                              : {{(CFG_DATA_W-SCALE_W){1'b0}}, scale_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      recip_q <= RECIP_RESET;
    end else if (cfg_wr) begin
      if (paddr[3] == CFG_SEL_SCALE) begin
        scale_q <= pwdata[SCALE_W-1:0];
      end else begin
        recip_q <= pwdata[RECIP_W-1:0];
      end
    end
  end

  // handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= CH_LEFT;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_MUL_LO;
          ch_d    = CH_LEFT;
        end
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUM;
      ST_SUM:    state_d = ST_MUL_RC;
      ST_MUL_RC: state_d = ST_FIN;
      ST_FIN: begin
        if (ch_q == CH_LEFT) begin
          state_d = ST_MUL_LO;
          ch_d    = CH_RIGHT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = {smp_q[ch_q][31], smp_q[ch_q]};
    mul_b = {15'b0, scale_q[15:0]};
    case (state_q)
      ST_MUL_HI: mul_b = {7'b0, scale_q[39:16]};
      ST_MUL_RC: begin
        mul_a = {{7{qnt_q[25]}}, qnt_q};
        mul_b = {1'b0, recip_q};
      end
      default: mul_b = {15'b0, scale_q[15:0]};
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // dither term and sums
  assign prng_cur  = prng_q[ch_q];
  assign hist_old  = hist_q[ch_q][DITHER_DELAY-1];
  assign dith_diff = $signed({1'b0, prng_cur}) - $signed({1'b0, hist_old});
  assign e_sum     = $signed(prod_q[49:0]) + $signed({{2{dith_diff[32]}}, dith_diff, 15'b0});
  assign t_sum     = $signed(prod_q[56:0]) + $signed({{23{e_q[49]}}, e_q[49:16]});

  // round half up, then saturate
  assign v_rnd   = prod_q + RND_HALF;
  assign r_val   = v_rnd >>> RND_K;
  assign r_sat   = (r_val > SAT_MAX) ? SAT_MAX : ((r_val < SAT_MIN) ? SAT_MIN : r_val);
  assign res_cur = r_sat[31:0];

  // input capture, sample widened to Q1.31
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q[CH_LEFT]  <= s_axis_tdata[31:0] << IN_SHIFT;
      smp_q[CH_RIGHT] <= s_axis_tdata[63:32] << IN_SHIFT;
      last_q          <= s_axis_tlast;
    end
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk_i) begin
    if (state_q inside {ST_MUL_LO, ST_MUL_HI, ST_MUL_RC}) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_MUL_HI) begin
      e_q <= e_sum;
    end
    if (state_q == ST_SUM) begin
      qnt_q <= t_sum[56:31];
    end
    if (state_q == ST_FIN && ch_q == CH_LEFT) begin
      res_left_q <= res_cur;
    end
    // right result is latched in its final step and held here
    if (state_q == ST_FIN && ch_q == CH_RIGHT) begin
      res_right_q <= res_cur;
    end
  end

  // generators and dither history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prng_q[CH_LEFT]  <= SEED_LEFT;
      prng_q[CH_RIGHT] <= SEED_RIGHT;
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < DITHER_DELAY; i++) begin
          hist_q[c][i] <= '0;
        end
      end
    end else begin
      if (state_q == ST_MUL_LO) begin
        prng_q[ch_q] <= xs_next(prng_cur);
      end
      if (state_q == ST_FIN) begin
        prng_q[ch_q] <= xs_next(prng_cur);
        for (int i = DITHER_DELAY - 1; i > 0; i--) begin
          hist_q[ch_q][i] <= hist_q[ch_q][i-1];
        end
        hist_q[ch_q][0] <= prng_cur;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {res_right_q, res_left_q};
      out_last_q <= last_q;
    end
  end

endmodule

[bench/tb_stereo_highpass_dither_quantizer.sv]
// ----------------------------------------------------------------------------
// tb_stereo_highpass_dither_quantizer: self-checking bench for the quantizer
// Streams stereo sample pairs through the block over several register
// settings and idle patterns. An in-bench model predicts every quantized
// pair, and each output item is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_stereo_highpass_dither_quantizer
  import shdq_pkg::*;
();

  localparam int unsigned HIST_DEPTH  = DITHER_DELAY_DEF;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS = 225;
  localparam int unsigned SETTLE_CYC  = 40;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_PRINTS  = 50;
  localparam longint      SAMPLE_MAX  = 64'sd2147483647;
  localparam longint      SAMPLE_MIN  = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic        last;
  } sample_pair_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata  = '0;  // sample_left, sample_right
  logic                  s_axis_tlast  = 1'b0;  // block_end
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [63:0]           m_axis_tdata;  // out_left, out_right
  logic                  m_axis_tlast;  // block_end_out
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  stereo_highpass_dither_quantizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model state: registers, generators and dither history per channel
  logic [SCALE_W-1:0] scale_q = SCALE_RESET;
  logic [RECIP_W-1:0] recip_q = RECIP_RESET;
  logic [31:0]        noise_word [2] = '{SEED_LEFT, SEED_RIGHT};
  logic [31:0]        dither_hist [2][HIST_DEPTH];

  sample_pair_t pending_pairs [$];
  sample_pair_t quantized_pairs [$];
  sample_pair_t in_flight;

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  initial begin
    for (int c = 0; c < 2; c++)
      for (int i = 0; i < HIST_DEPTH; i++)
        dither_hist[c][i] = '0;
  end

  // xorshift32 step
  function automatic logic [31:0] advance_noise(input logic [31:0] x);
    logic [31:0] t;
    t = x ^ (x << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  // one channel: scale, add highpassed dither, floor, rescale, round, clamp
  function automatic logic [31:0] quantize_channel(input logic [31:0] smp, input int ch);
    longint s, a, b, c, e, q, v, r;
    logic [31:0] d;
    noise_word[ch] = advance_noise(noise_word[ch]);
    d = noise_word[ch];
    s = $signed(smp);
    a = s * longint'(scale_q[39:16]);
    b = s * longint'(scale_q[15:0]);
    c = (longint'(d) - longint'(dither_hist[ch][HIST_DEPTH-1])) * 32768;
    e = b + c;
    q = (a + (e >>> 16)) >>> 31;
    for (int i = HIST_DEPTH - 1; i > 0; i--)
      dither_hist[ch][i] = dither_hist[ch][i-1];
    dither_hist[ch][0] = d;
    v = q * longint'(recip_q);
    // round half up from units 2^-32 to 2^-31
    r = (v + 1) >>> 1;
    if (r > SAMPLE_MAX) r = SAMPLE_MAX;
    if (r < SAMPLE_MIN) r = SAMPLE_MIN;
    noise_word[ch] = advance_noise(noise_word[ch]);
    return r[31:0];
  endfunction

  function automatic sample_pair_t predict_quantized_pair(input sample_pair_t item);
    sample_pair_t res;
    res.left  = quantize_channel(item.left, int'(CH_LEFT));
    res.right = quantize_channel(item.right, int'(CH_RIGHT));
    res.last  = item.last;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // keep the log short on a badly broken block
    if (fail_count < MAX_PRINTS)
      $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
    fail_count++;
  endtask

  // driver: present pending items, predict at acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        quantized_pairs.push_back(predict_quantized_pair(in_flight));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_flight = pending_pairs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {in_flight.right, in_flight.left};
          s_axis_tlast  <= in_flight.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each output item with the oldest prediction
  always @(posedge clk_i) begin
    sample_pair_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (quantized_pairs.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata[31:0], '0);
        end else begin
          want = quantized_pairs.pop_front();
          if (m_axis_tdata[31:0] !== want.left)
            report_mismatch("out_left", m_axis_tdata[31:0], want.left);
          if (m_axis_tdata[63:32] !== want.right)
            report_mismatch("out_right", m_axis_tdata[63:32], want.right);
          if (m_axis_tlast !== want.last)
            report_mismatch("block_end_out", 32'(m_axis_tlast), 32'(want.last));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_stereo_highpass_dither_quantizer failed");
      $finish;
    end
  end

  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper data bits carry junk the block must drop
  task automatic write_scale(input logic [SCALE_W-1:0] value);
    apb_write({CFG_SEL_SCALE, 3'b000}, {24'($urandom()), value});
    scale_q = value;
  endtask

  task automatic write_recip(input logic [RECIP_W-1:0] value);
    apb_write({CFG_SEL_RECIP, 3'b000}, {2'($urandom()), $urandom(), value});
    recip_q = value;
  endtask

  task automatic push_pair(input logic [31:0] l, input logic [31:0] r, input logic last);
    sample_pair_t item;
    item.left  = l;
    item.right = r;
    item.last  = last;
    pending_pairs.push_back(item);
  endtask

  // full-range words four times in ten, else extremes, zeros and tiny values
  function automatic logic [31:0] random_sample();
    logic [31:0] v;
    case ($urandom_range(9))
      0: v = 32'h0000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h8000_0000;
      3: v = 32'($urandom_range(255));
      4: v = -32'($urandom_range(256));
      5: v = 32'($urandom()) >>> $urandom_range(31);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // waits at falling edges so the driver's updates have settled
  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (pending_pairs.size() != 0 || s_axis_tvalid || quantized_pairs.size() != 0);
  endtask

  task automatic configure_phase(input int unsigned p);
    logic [SCALE_W-1:0] sc;
    logic [RECIP_W-1:0] rc;
    sc = 40'({$urandom(), $urandom()}) & 40'h7F_FFFF_FFFF;
    if (sc < 40'd7) sc = 40'd7;
    rc = 30'($urandom()) & 30'h1FFF_FFFF;
    case (p)
      0: ;  // reset values
      1: begin write_scale(40'h80_0000_0000); write_recip(30'd512); end
      2: begin write_scale(40'd7); write_recip(30'h2000_0000); end
      3: begin write_scale(40'hFF_FFFF_FFFF); write_recip(30'h3FFF_FFFF); end
      4: begin write_scale(40'd0); write_recip(30'h2000_0000); end
      5: begin write_scale(SCALE_RESET); write_recip(RECIP_RESET); end
      default: begin write_scale(sc); write_recip(rc); end
    endcase
    @(negedge clk_i);
    case (p % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
      default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
    endcase
  endtask

  // stimulus and end of run
  initial begin
    int unsigned n;
    int unsigned run_len;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      // the sender holds off until every prediction is met before a rewrite
      configure_phase(p);
      if (p == 0) begin
        // zero input while the dither history fills
        repeat (4) push_pair(32'h0, 32'h0, 1'b0);
        push_pair(32'h0, 32'h0, 1'b1);
        push_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        push_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        push_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
        push_pair(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        push_pair(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        push_pair(32'h4000_0000, 32'hC000_0000, 1'b0);
        push_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        push_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        push_pair(32'h0001_0000, 32'hFFFF_0000, 1'b0);
        push_pair(32'h0, 32'h0, 1'b1);
      end
      // blocks of random length ending in block_end, with stray marks
      n = 0;
      while (n < PHASE_ITEMS) begin
        run_len = $urandom_range(16, 1);
        for (int unsigned i = 0; i < run_len; i++)
          push_pair(random_sample(), random_sample(),
                    (i == run_len - 1) || ($urandom_range(15) == 0));
        n += run_len;
      end
      wait_until_drained();
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (quantized_pairs.size() != 0)
      report_mismatch("items never delivered", 32'(quantized_pairs.size()), '0);
    if (fail_count == 0) begin
      $display("tb_stereo_highpass_dither_quantizer passed");
    end else begin
      $display("tb_stereo_highpass_dither_quantizer failed");
    end
    $finish;
  end

endmodule
